/* hdl/piecewise_linear_interp_table_top_macros.svh */
// Assertion macros shared by the piecewise linear interpolation table RTL
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_TOP_MACROS_SVH

// Check a property on every rising edge outside reset
`define PLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define PLI_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pli_pkg.sv */
// Types and constants of the piecewise linear interpolation table
package pli_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DiffW = 33;
  localparam int unsigned ProdW = 66;
  localparam int unsigned StepW = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  typedef struct packed {
    logic                     any;
    logic                     found;
    logic                     first;
    logic                     dup;
    logic signed [DataW-1:0]  x0;
    logic signed [DataW-1:0]  y0;
    logic signed [DataW-1:0]  x1;
    logic signed [DataW-1:0]  y1;
  } carry_t;

endpackage

/* hdl/pli_if.sv */
// Valid/ready channel interfaces for input and result beats
interface pli_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [31:0] abscissa;
  logic signed [31:0] ordinate;

  modport source (output valid, opcode, abscissa, ordinate, input ready);
  modport sink (input valid, opcode, abscissa, ordinate, output ready);
endinterface

interface pli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic               is_constant;
  logic [6:0]         point_count;

  modport source (output valid, result_value, status, is_constant, point_count, input ready);
  modport sink (input valid, result_value, status, is_constant, point_count, output ready);
endinterface

/* hdl/pli_cell.sv */
// One breakpoint cell: holds a point, shifts on insert, passes the search carry
module pli_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [31:0]       x_in,
  input  logic signed [31:0]       y_in,
  input  logic                     ins_en,
  input  logic                     valid,
  input  logic signed [31:0]       prev_key,
  input  logic signed [31:0]       prev_val,
  input  logic                     prev_ge,
  input  logic                     tok_in,
  input  pli_pkg::carry_t          carry_in,
  output logic signed [31:0]       key,
  output logic signed [31:0]       val,
  output logic                     ge,
  output logic                     tok_out,
  output pli_pkg::carry_t          carry_out
);

  logic signed [31:0] key_r;
  logic signed [31:0] val_r;
  logic               tok_r;
  pli_pkg::carry_t    carry_r;
  pli_pkg::carry_t    carry_nxt;

  assign ge = valid && (key_r >= x_in);

  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (prev_ge) begin
        key_r <= prev_key;
        val_r <= prev_val;
      end else if (ge || !valid) begin
        key_r <= x_in;
        val_r <= y_in;
      end
    end
  end

  always_comb begin
    carry_nxt = carry_in;
    if (valid) begin
      if (key_r == x_in) carry_nxt.dup = 1'b1;
      if (!carry_in.found) begin
        if (ge) begin
          carry_nxt.found = 1'b1;
          carry_nxt.first = !carry_in.any;
          carry_nxt.x1    = key_r;
          carry_nxt.y1    = val_r;
        end else begin
          carry_nxt.any = 1'b1;
          carry_nxt.x0  = key_r;
          carry_nxt.y0  = val_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) carry_r <= carry_nxt;
  end

  assign key       = key_r;
  assign val       = val_r;
  assign tok_out   = tok_r;
  assign carry_out = carry_r;

endmodule

/* hdl/pli_div.sv */
// Restoring divider, one quotient bit per cycle
module pli_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pli_pkg::ProdW-1:0]     dividend,
  input  logic [pli_pkg::DiffW-1:0]     divisor,
  output logic                          done,
  output logic [pli_pkg::DiffW-1:0]     quotient
);

  logic [pli_pkg::ProdW-1:0] q_r;
  logic [pli_pkg::DiffW-1:0] rem_r;
  logic [pli_pkg::DiffW-1:0] div_r;
  logic [pli_pkg::StepW-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [pli_pkg::DiffW:0]   trial;
  logic [pli_pkg::DiffW:0]   diff;
  logic                      take;

  assign trial = {rem_r, q_r[pli_pkg::ProdW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign take  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pli_pkg::StepW'(pli_pkg::ProdW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[pli_pkg::DiffW-1:0] : trial[pli_pkg::DiffW-1:0];
      q_r   <= {q_r[pli_pkg::ProdW-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = q_r[pli_pkg::DiffW-1:0];

endmodule

/* hdl/piecewise_linear_interp_table_top.sv */
// Top level of the piecewise linear interpolation table
//
// Input channel in_ch takes one beat per operation: insert a breakpoint,
// query an interpolated ordinate, or clear the table. Result channel out_ch
// returns exactly one beat per input beat, in order, with the value, status,
// one-point flag and point count after the operation.
// Breakpoints sit in a row of TABLE_DEPTH cells, sorted by abscissa. Insert
// and query walk a search token down the row, one cell per cycle.
// Clear and unused opcodes go from idle straight to the output state. Insert
// and query sweep the row and then evaluate; a query that clamps goes on to
// the output, and one that interpolates adds a multiply, a divider start and
// the divide until the divider signals done.
// One item is in flight at a time.
// The next input beat is taken once the previous result sits in the output
// register; a stalled receiver holds that register and then the block.
// Reset empties the table at once; no clearing pass is needed.
`include "piecewise_linear_interp_table_top_macros.svh"

module piecewise_linear_interp_table_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  pli_in_if.sink    in_ch,
  pli_out_if.source out_ch
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_EVAL, S_MUL, S_DIV, S_OUT
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          count_r;
  logic [1:0]             op_r;
  logic signed [31:0]     x_r;
  logic signed [31:0]     y_r;
  logic                   start_r;
  pli_pkg::carry_t        fin_r;
  logic                   neg_r;
  logic [pli_pkg::DiffW-1:0] mag_r;
  logic [pli_pkg::DiffW-1:0] dt_r;
  logic [pli_pkg::DiffW-1:0] dx_r;
  logic [pli_pkg::ProdW-1:0] prod_r;
  logic                   div_start_r;
  logic signed [31:0]     res_r;
  logic [1:0]             st_r;
  logic                   out_valid_r;
  logic signed [31:0]     out_value_r;
  logic [1:0]             out_status_r;
  logic                   out_const_r;
  logic [6:0]             out_count_r;

  logic                   ins_en;
  logic                   full;
  logic                   div_done;
  logic [pli_pkg::DiffW-1:0] quot;
  logic signed [pli_pkg::DiffW-1:0] dy;
  logic [pli_pkg::DiffW-1:0] dx;
  logic [pli_pkg::DiffW-1:0] dt;

  logic signed [31:0]     key_w [TABLE_DEPTH];
  logic signed [31:0]     val_w [TABLE_DEPTH];
  logic                   ge_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tok_w;
  logic [TABLE_DEPTH-1:0] valid_w;
  pli_pkg::carry_t        carry_w [TABLE_DEPTH];

  assign full   = count_r == CW'(TABLE_DEPTH);
  assign ins_en = (state_r == S_EVAL) && (op_r == pli_pkg::OP_INSERT)
                  && !fin_r.dup && !full;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign valid_w[g] = CW'(g) < count_r;
      if (g == 0) begin : g_head
        pli_cell u_cell (
          .clk(clk), .rst_n(rst_n), .x_in(x_r), .y_in(y_r), .ins_en(ins_en),
          .valid(valid_w[g]), .prev_key(32'sd0), .prev_val(32'sd0),
          .prev_ge(1'b0), .tok_in(start_r), .carry_in('0),
          .key(key_w[g]), .val(val_w[g]), .ge(ge_w[g]),
          .tok_out(tok_w[g]), .carry_out(carry_w[g])
        );
      end else begin : g_body
        pli_cell u_cell (
          .clk(clk), .rst_n(rst_n), .x_in(x_r), .y_in(y_r), .ins_en(ins_en),
          .valid(valid_w[g]), .prev_key(key_w[g-1]), .prev_val(val_w[g-1]),
          .prev_ge(ge_w[g-1]), .tok_in(tok_w[g-1]), .carry_in(carry_w[g-1]),
          .key(key_w[g]), .val(val_w[g]), .ge(ge_w[g]),
          .tok_out(tok_w[g]), .carry_out(carry_w[g])
        );
      end
    end
  endgenerate

  pli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(prod_r),
    .divisor(dx_r), .done(div_done), .quotient(quot)
  );

  assign dy = pli_pkg::DiffW'(fin_r.y1) - pli_pkg::DiffW'(fin_r.y0);
  assign dx = pli_pkg::DiffW'(fin_r.x1) - pli_pkg::DiffW'(fin_r.x0);
  assign dt = pli_pkg::DiffW'(x_r) - pli_pkg::DiffW'(fin_r.x0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r  <= in_ch.opcode;
            x_r   <= in_ch.abscissa;
            y_r   <= in_ch.ordinate;
            res_r <= '0;
            st_r  <= pli_pkg::ST_OK;
            if (in_ch.opcode == pli_pkg::OP_CLEAR) begin
              count_r <= '0;
              state_r <= S_OUT;
            end else if (in_ch.opcode == pli_pkg::OP_NONE) begin
              state_r <= S_OUT;
            end else begin
              start_r <= 1'b1;
              state_r <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (tok_w[TABLE_DEPTH-1]) begin
            fin_r   <= carry_w[TABLE_DEPTH-1];
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_OUT;
          if (op_r == pli_pkg::OP_INSERT) begin
            if (fin_r.dup) st_r <= pli_pkg::ST_DUP;
            else if (full) st_r <= pli_pkg::ST_FULL;
            else count_r <= count_r + 1'b1;
          end else if (count_r == '0) begin
            st_r <= pli_pkg::ST_EMPTY;
          end else if (!fin_r.found) begin
            res_r <= fin_r.y0;
          end else if (fin_r.first) begin
            res_r <= fin_r.y1;
          end else begin
            neg_r   <= dy[pli_pkg::DiffW-1];
            mag_r   <= dy[pli_pkg::DiffW-1] ? pli_pkg::DiffW'(-dy) : pli_pkg::DiffW'(dy);
            dt_r    <= dt;
            dx_r    <= dx;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r      <= pli_pkg::ProdW'(mag_r) * pli_pkg::ProdW'(dt_r);
          div_start_r <= 1'b1;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= neg_r ? fin_r.y0 - 32'(quot) : fin_r.y0 + 32'(quot);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_r;
            out_status_r <= st_r;
            out_const_r  <= count_r == CW'(1);
            out_count_r  <= 7'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.is_constant  = out_const_r;
  assign out_ch.point_count  = out_count_r;

  `PLI_ASSERT(a_count_bound, count_r <= CW'(TABLE_DEPTH), "point count above table depth")
  `PLI_ASSERT(a_token_single, $onehot0(tok_w), "more than one search token in the row")
  `PLI_ASSERT_NEXT(a_insert_grows, ins_en, count_r == $past(count_r) + 1'b1, "insert lost count")
  `PLI_ASSERT(a_div_in_state, !div_done || state_r == S_DIV, "divider done outside divide")

endmodule
